// ----- rtl/fcca_pkg.sv -----
// shared types and constants of the cluster chain allocator
package fcca_pkg;

  localparam int KIND_W = 2;
  localparam int LEN_W  = 14;
  localparam int CL_W   = 6;
  localparam int LINK_W = 8;

  localparam logic [LINK_W-1:0] LINK_FREE = 8'h00;
  localparam logic [LINK_W-1:0] LINK_END  = 8'hFF;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_WALK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACNT,
    ST_ALINK,
    ST_AEND,
    ST_FREE,
    ST_WALK,
    ST_RESP
  } state_e;

  // one write and one read of the link table per cycle
  typedef struct packed {
    logic              we;
    logic [CL_W-1:0]   waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [CL_W-1:0]   raddr;
  } mem_req_t;

endpackage

// ----- rtl/fcca_len_unit.sv -----
// shared length unit: saturating subtract of one cluster's bytes
module fcca_len_unit #(
  parameter int CLUSTER_BYTES = 128
) (
  input  logic [fcca_pkg::LEN_W-1:0] rem_i,
  output logic [fcca_pkg::LEN_W-1:0] rem_o,
  output logic                       zero_o
);
  import fcca_pkg::*;

  localparam logic [LEN_W-1:0] CB = LEN_W'(CLUSTER_BYTES);

  assign rem_o  = (rem_i > CB) ? (rem_i - CB) : '0;
  assign zero_o = (rem_o == '0);

endmodule

// ----- rtl/fcca_link_mem.sv -----
// link table memory with a free map kept in flip-flops
module fcca_link_mem #(
  parameter int CLUSTERS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcca_pkg::mem_req_t          req_i,
  output logic [CLUSTERS-1:0]         free_o,
  output logic [fcca_pkg::LINK_W-1:0] rd_link_o
);
  import fcca_pkg::*;

  localparam int IW = $clog2(CLUSTERS);

  logic [LINK_W-1:0] mem_q [CLUSTERS];
  logic [CLUSTERS-1:0] free_q;
  logic [LINK_W-1:0] rd_data_q;
  logic rd_free_q;

  // free map, all entries free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q    <= '1;
      rd_free_q <= 1'b1;
    end else begin
      if (req_i.we) begin
        free_q[req_i.waddr[IW-1:0]] <= (req_i.wdata == LINK_FREE);
      end
      if (req_i.re) begin
        rd_free_q <= free_q[req_i.raddr[IW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[IW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr[IW-1:0]];
    end
  end

  assign free_o    = free_q;
  assign rd_link_o = rd_free_q ? LINK_FREE : rd_data_q;

endmodule

// ----- rtl/fat_cluster_chain_allocator.sv -----
// top level of the cluster chain allocator: sequencer, registers and output stage
// Keeps a table of CLUSTERS link entries and serves three kinds of request. Allocate
// scans the free map first-fit, one entry a cycle, counting until enough clusters are
// found (stopping early) and then scans again linking the clusters it takes, and answers
// once with the first cluster, or with status 1 and nothing changed when the table is
// too full. Free follows the chain one link a cycle through the registered table read
// port, clearing as it goes, and answers once with the start cluster. Walk emits one
// cluster per cycle while the output is not stalled, up to CLUSTERS results, the final
// one with last set. The byte length is reduced by CLUSTER_BYTES per cluster in one
// shared subtractor, so no division is needed. Kind 3 is taken and dropped. No new
// request is taken while one is at work, but a request may be taken while the last
// result still waits in the output register.
module fat_cluster_chain_allocator #(
  parameter int CLUSTERS      = 64,
  parameter int CLUSTER_BYTES = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fcca_pkg::KIND_W-1:0] in_kind_i,
  input  logic [fcca_pkg::LEN_W-1:0]  in_byte_len_i,
  input  logic [fcca_pkg::CL_W-1:0]   in_start_cluster_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_status_o,
  output logic [fcca_pkg::CL_W-1:0]   out_cluster_o,
  output logic                        out_last_o
);
  import fcca_pkg::*;

  localparam int IW = $clog2(CLUSTERS);

  state_e state_q, state_d;

  logic [LEN_W-1:0] rem_q, rem_d, len_q, len_d;
  logic [IW-1:0]    idx_q, idx_d, prev_q, prev_d;
  logic [CL_W-1:0]  cur_q, cur_d, res_q, res_d;
  logic             res_status_q, res_status_d;
  logic             any_q, any_d;

  logic             out_valid_q, out_valid_d;
  logic             out_status_q, out_status_d;
  logic [CL_W-1:0]  out_cluster_q, out_cluster_d;
  logic             out_last_q, out_last_d;
  logic             out_load;

  mem_req_t          mem_req;
  logic [CLUSTERS-1:0] free_vec;
  logic [LINK_W-1:0] e_link;

  logic [LEN_W-1:0] rem_next;
  logic             rem_zero_next;

  logic in_acc, out_free;
  logic take, any_n, sat, last_idx;
  logic cur_ok, e_in, e_ok, free_more, walk_stop;
  logic [LEN_W-1:0] rem_sel;

  // shared length subtractor
  fcca_len_unit #(
    .CLUSTER_BYTES(CLUSTER_BYTES)
  ) u_len (
    .rem_i (rem_q),
    .rem_o (rem_next),
    .zero_o(rem_zero_next)
  );

  fcca_link_mem #(
    .CLUSTERS(CLUSTERS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .free_o   (free_vec),
    .rd_link_o(e_link)
  );

  // handshakes, the output register frees when empty or being taken
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // first-fit scan terms
  assign take     = free_vec[idx_q];
  assign any_n    = any_q || take;
  assign rem_sel  = take ? rem_next : rem_q;
  assign sat      = any_n && (rem_sel == '0);
  assign last_idx = (idx_q == IW'(CLUSTERS - 1));

  // chain following terms
  assign cur_ok    = ((CL_W + 1)'(cur_q) < (CL_W + 1)'(CLUSTERS));
  assign e_in      = (e_link < LINK_W'(CLUSTERS));
  assign e_ok      = (e_link != LINK_FREE) && (e_link != LINK_END) && e_in;
  assign free_more = cur_ok && e_ok && !last_idx;
  assign walk_stop = rem_zero_next || last_idx || !cur_ok || !e_ok;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(in_kind_i))
            KIND_ALLOC: state_d = ST_ACNT;
            KIND_FREE:  state_d = ST_FREE;
            KIND_WALK:  state_d = ST_WALK;
            KIND_NONE:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACNT: begin
        if (sat) begin
          state_d = ST_ALINK;
        end else if (last_idx) begin
          state_d = ST_RESP;
        end
      end
      ST_ALINK: begin
        if (take && sat) begin
          state_d = ST_AEND;
        end
      end
      ST_AEND: state_d = ST_RESP;
      ST_FREE: begin
        if (!free_more) begin
          state_d = ST_RESP;
        end
      end
      ST_WALK: begin
        if (out_free && walk_stop) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath, table access and output loads
  always_comb begin
    rem_d         = rem_q;
    len_d         = len_q;
    idx_d         = idx_q;
    prev_d        = prev_q;
    cur_d         = cur_q;
    res_d         = res_q;
    res_status_d  = res_status_q;
    any_d         = any_q;
    mem_req       = '0;
    out_load      = 1'b0;
    out_status_d  = out_status_q;
    out_cluster_d = out_cluster_q;
    out_last_d    = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rem_d         = in_byte_len_i;
          len_d         = in_byte_len_i;
          idx_d         = '0;
          any_d         = 1'b0;
          cur_d         = in_start_cluster_i;
          res_d         = in_start_cluster_i;
          res_status_d  = STATUS_OK;
          mem_req.re    = 1'b1;
          mem_req.raddr = in_start_cluster_i;
        end
      end
      ST_ACNT: begin
        // counting pass, nothing written
        any_d = any_n;
        rem_d = rem_sel;
        if (sat) begin
          rem_d = len_q;
          any_d = 1'b0;
          idx_d = '0;
        end else if (last_idx) begin
          res_status_d = STATUS_FULL;
          res_d        = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_ALINK: begin
        // linking pass, each taken cluster links from the one before
        if (take) begin
          any_d  = 1'b1;
          rem_d  = rem_next;
          prev_d = idx_q;
          if (!any_q) begin
            res_d = CL_W'(idx_q);
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = CL_W'(prev_q);
            mem_req.wdata = LINK_W'(idx_q);
          end
        end
        idx_d = idx_q + 1'b1;
      end
      ST_AEND: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = CL_W'(prev_q);
        mem_req.wdata = LINK_END;
      end
      ST_FREE: begin
        if (cur_ok && (e_link != LINK_FREE)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cur_q;
          mem_req.wdata = LINK_FREE;
        end
        if (free_more) begin
          cur_d         = e_link[CL_W-1:0];
          idx_d         = idx_q + 1'b1;
          mem_req.re    = 1'b1;
          mem_req.raddr = e_link[CL_W-1:0];
        end
      end
      ST_WALK: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_status_d  = STATUS_OK;
          out_cluster_d = cur_q;
          out_last_d    = walk_stop;
          if (!walk_stop) begin
            cur_d         = e_link[CL_W-1:0];
            idx_d         = idx_q + 1'b1;
            rem_d         = rem_next;
            mem_req.re    = 1'b1;
            mem_req.raddr = e_link[CL_W-1:0];
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_status_d  = res_status_q;
          out_cluster_d = res_q;
          out_last_d    = 1'b1;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      any_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      any_q       <= any_d;
      idx_q       <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    len_q         <= len_d;
    prev_q        <= prev_d;
    cur_q         <= cur_d;
    res_q         <= res_d;
    res_status_q  <= res_status_d;
    out_status_q  <= out_status_d;
    out_cluster_q <= out_cluster_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_cluster_o = out_cluster_q;
  assign out_last_o    = out_last_q;

  // links always point upwards in the table
  a_link_ascends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALINK && mem_req.we) |-> (prev_q < idx_q))
    else $error("allocation wrote a link that does not ascend");

  // walk requests never modify the table
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == ST_ALINK || state_q == ST_AEND || state_q == ST_FREE))
    else $error("table written outside allocate or free");

  // a full table answer is always the only transfer of its request
  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> out_last_q)
    else $error("table full result without last");

  // a walk result without last keeps the walk going
  a_walk_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && out_load && !out_last_d) |=> (state_q == ST_WALK))
    else $error("walk left early");

endmodule
